>>> design/lsr_pkg.sv
// Package for the line spike remover: shared types and constants.
// Used by line_spike_remover and lsr_div; depends on nothing.
package lsr_pkg;

  localparam int WIN         = 5;
  localparam int LAG         = 3;
  localparam int DEPTH       = 7;
  localparam int SCALE_W     = 16;
  localparam int TOL_W       = 24;
  localparam int CFG_W       = 24;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  typedef enum logic [0:0] {
    REG_SCALE = 1'b0,
    REG_TOL   = 1'b1
  } reg_idx_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PRE  = 7'b0000010,
    S_DEV  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_CMP  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  typedef logic [2:0] cnt_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> design/lsr_in_if.sv
// Input channel of the line spike remover: valid, ready, one pixel and a line end flag.
// Depends on nothing.
interface lsr_in_if #(parameter int PIXEL_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel_in;
  logic                         line_end_in;
  modport source (output valid, pixel_in, line_end_in, input ready);
  modport sink   (input valid, pixel_in, line_end_in, output ready);
endinterface

>>> design/lsr_out_if.sv
// Output channel of the line spike remover: valid, ready, one result pixel, a replaced flag and a line end flag.
// Depends on nothing.
interface lsr_out_if #(parameter int PIXEL_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel_out;
  logic                         replaced;
  logic                         line_end_out;
  modport source (output valid, pixel_out, replaced, line_end_out, input ready);
  modport sink   (input valid, pixel_out, replaced, line_end_out, output ready);
endinterface

>>> design/line_spike_remover.sv
// Line spike remover: one pixel transaction in, results three pixels behind.
// A decision result follows its accepted pixel through S_DEV, S_MUL and S_CMP,
// and through the serial divider in S_DIV when the pixel is replaced.
// The next pixel is taken in the cycle after the result is accepted, not before;
// a line end flushes up to 4 results, after edge shifts in S_PRE when the line is short.
// Synchronous reset sets scale to 1.0, tolerance to 0 and starts a new line.
module line_spike_remover import lsr_pkg::*; #(
  parameter int PIXEL_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  lsr_in_if.sink           pixels,
  lsr_out_if.source        results
);

  localparam int P  = PIXEL_BITS;
  localparam int SW = P + 2;
  localparam int NW = P + 4;
  localparam int CW = P + 20;
  localparam int RW = P + 24;

  logic [SCALE_W-1:0] scale;
  logic [TOL_W-1:0]   tol;
  state_t             state;
  cnt_t               pos, lcnt, rcnt, pre;
  logic               flush;

  logic               acc, out_acc, load_all, shift;
  logic signed [P-1:0] fill;
  logic signed [P-1:0] win [DEPTH];
  logic signed [P-1:0] wl [5], wc [5], wr [5];
  logic [P-1:0]       dev_l, dev_c, dev_r;

  logic [P-1:0]       dev1_r;
  logic [P+1:0]       dsum_r;
  logic signed [SW-1:0] s_r;
  logic [2:0]         n_r;
  logic [P:0]         d_r;
  logic [1:0]         dc_r;
  logic signed [NW-1:0] num_r;
  logic [P+17:0]      prod_a;
  logic [P+16:0]      prod_b;

  logic signed [SW-1:0] s_c;
  logic [2:0]         n_c;
  logic [P:0]         d_c;
  logic [1:0]         dc_c;
  logic [1:0]         dc_eff;
  logic [CW-1:0]      lhs1, rhs1;
  logic [RW-1:0]      lhs2, rhs2;
  logic               rep_c;

  logic signed [SW:0] s_ext, s_neg_v;
  logic [SW-1:0]      s_mag, quot, quot_neg;
  logic               s_neg;
  logic               div_start;
  div_status_t        div_st;

  logic signed [P-1:0] opix;
  logic               orep, oend;

  function automatic logic [P-1:0] absdiff(input logic signed [P-1:0] a,
                                           input logic signed [P-1:0] b);
    logic signed [P:0] df;
    logic signed [P:0] ng;
    df = (P+1)'(a) - (P+1)'(b);
    ng = -df;
    return df[P] ? ng[P-1:0] : df[P-1:0];
  endfunction

  assign pixels.ready  = (state == S_IDLE);
  assign acc           = pixels.valid && pixels.ready;
  assign results.valid = (state == S_OUT);
  assign out_acc       = results.valid && results.ready;
  assign results.pixel_out    = opix;
  assign results.replaced     = orep;
  assign results.line_end_out = oend;

  // Without a new pixel the newest one is copied, which replicates the right edge.
  assign fill     = acc ? pixels.pixel_in : win[DEPTH-1];
  assign load_all = acc && (pos == 3'd0);
  assign shift    = acc || (state == S_PRE) || (out_acc && flush && rcnt != 3'd0);

  // Cell 6 holds the newest pixel, cell 3 the pixel under decision.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    lsr_cell #(.PIXEL_BITS(P)) u_cell (
      .clk      (clk),
      .load_all (load_all),
      .shift    (shift),
      .fill     (fill),
      .neighbor ((k == DEPTH-1) ? fill : win[(k + 1) % DEPTH]),
      .q        (win[k])
    );
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      wl[i] = win[i];
      wc[i] = win[i+1];
      wr[i] = win[i+2];
    end
  end

  lsr_dev5 #(.PIXEL_BITS(P)) u_dev_l (.win(wl), .dev(dev_l));
  lsr_dev5 #(.PIXEL_BITS(P)) u_dev_c (.win(wc), .dev(dev_c));
  lsr_dev5 #(.PIXEL_BITS(P)) u_dev_r (.win(wr), .dev(dev_r));

  // Neighbor sum, count and outer differences for the pixel in cell 3.
  always_comb begin
    s_c  = '0;
    n_c  = '0;
    d_c  = '0;
    dc_c = '0;
    if (lcnt >= 3'd2) begin
      s_c  = s_c + SW'(win[1]);
      n_c  = n_c + 3'd1;
      d_c  = d_c + (P+1)'(absdiff(win[2], win[1]));
      dc_c = dc_c + 2'd1;
    end
    if (lcnt >= 3'd1) begin
      s_c = s_c + SW'(win[2]);
      n_c = n_c + 3'd1;
    end
    if (rcnt >= 3'd1) begin
      s_c = s_c + SW'(win[4]);
      n_c = n_c + 3'd1;
    end
    if (rcnt >= 3'd2) begin
      s_c  = s_c + SW'(win[5]);
      n_c  = n_c + 3'd1;
      d_c  = d_c + (P+1)'(absdiff(win[4], win[5]));
      dc_c = dc_c + 2'd1;
    end
  end

  assign dc_eff = (dc_r == 2'd0) ? 2'd1 : dc_r;
  assign lhs1   = CW'(dev1_r) * CW'(11'd1280);
  assign rhs1   = CW'(prod_a) + CW'(tol) * CW'(3'd5);
  assign lhs2   = RW'(num_r[NW-2:0]) * RW'({dc_eff, 8'd0});
  assign rhs2   = RW'(n_r) * (RW'(prod_b) + RW'(tol) * RW'(dc_eff));
  assign rep_c  = (lhs1 > rhs1) && (n_r != 3'd0) && !num_r[NW-1] &&
                  (num_r != '0) && (lhs2 > rhs2);

  assign s_ext    = (SW+1)'(s_r);
  assign s_neg_v  = -s_ext;
  assign s_mag    = s_r[SW-1] ? s_neg_v[SW-1:0] : s_ext[SW-1:0];
  assign quot_neg = -quot;
  assign div_start = (state == S_CMP) && rep_c;

  lsr_div #(.MAG_BITS(SW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .mag     (s_mag),
    .divisor (n_r),
    .quot    (quot),
    .status  (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
      tol   <= '0;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_SCALE: scale <= cfg_data[SCALE_W-1:0];
        REG_TOL:   tol   <= cfg_data[TOL_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos   <= '0;
      lcnt  <= '0;
      rcnt  <= '0;
      pre   <= '0;
      flush <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            if (pixels.line_end_in) begin
              pos   <= '0;
              flush <= 1'b1;
              if (pos >= 3'd3) begin
                lcnt  <= pos - 3'd3;
                rcnt  <= 3'd3;
                state <= S_DEV;
              end else begin
                lcnt  <= '0;
                rcnt  <= pos;
                pre   <= 3'd3 - pos;
                state <= S_PRE;
              end
            end else begin
              pos <= (pos == 3'd7) ? pos : pos + 3'd1;
              if (pos >= 3'd3) begin
                lcnt  <= pos - 3'd3;
                rcnt  <= 3'd3;
                state <= S_DEV;
              end
            end
          end
        end
        S_PRE: begin
          pre <= pre - 3'd1;
          if (pre == 3'd1) begin
            state <= S_DEV;
          end
        end
        S_DEV: state <= S_MUL;
        S_MUL: state <= S_CMP;
        S_CMP: state <= rep_c ? S_DIV : S_OUT;
        S_DIV: begin
          if (div_st.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (flush && rcnt != 3'd0) begin
              lcnt  <= (lcnt == 3'd7) ? lcnt : lcnt + 3'd1;
              rcnt  <= rcnt - 3'd1;
              state <= S_DEV;
            end else begin
              flush <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the decision steps.
  always_ff @(posedge clk) begin
    if (state == S_DEV) begin
      dev1_r <= dev_c;
      dsum_r <= (P+2)'((lcnt >= 3'd1) ? dev_l : '0) + (P+2)'(dev_c) +
                (P+2)'((rcnt >= 3'd1) ? dev_r : '0);
      s_r    <= s_c;
      n_r    <= n_c;
      d_r    <= d_c;
      dc_r   <= dc_c;
      num_r  <= NW'(win[3]) * NW'($signed({1'b0, n_c})) - NW'(s_c);
    end
    if (state == S_MUL) begin
      prod_a <= scale * dsum_r;
      prod_b <= scale * d_r;
    end
    if (state == S_CMP) begin
      s_neg <= s_r[SW-1];
      if (!rep_c) begin
        opix <= win[3];
        orep <= 1'b0;
        oend <= flush && (rcnt == 3'd0);
      end
    end
    if (state == S_DIV && div_st.done) begin
      opix <= s_neg ? quot_neg[P-1:0] : quot[P-1:0];
      orep <= 1'b1;
      oend <= flush && (rcnt == 3'd0);
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(pixels.ready && results.valid))
    else $error("input accepted while a result is pending");

  a_flush_next: assert property (@(posedge clk) disable iff (rst)
    (out_acc && flush && rcnt != 3'd0) |=> (state == S_DEV))
    else $error("flush did not continue with the next pixel");

  a_right_count: assert property (@(posedge clk) disable iff (rst)
    rcnt <= 3'd3)
    else $error("right neighbor count out of range");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.busy |-> (state == S_DIV))
    else $error("divider busy outside the divide step");

endmodule

>>> design/lsr_cell.sv
// One pixel cell of the window chain: loads its neighbor on a shift,
// or the fill pixel at a line start. Depends on nothing.
module lsr_cell #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         load_all,
  input  logic                         shift,
  input  logic signed [PIXEL_BITS-1:0] fill,
  input  logic signed [PIXEL_BITS-1:0] neighbor,
  output logic signed [PIXEL_BITS-1:0] q
);

  // Loading every cell with the first pixel of a line replicates the left edge.
  always_ff @(posedge clk) begin
    if (load_all) begin
      q <= fill;
    end else if (shift) begin
      q <= neighbor;
    end
  end

endmodule

>>> design/lsr_dev5.sv
// Absolute deviation of the center of a 5-pixel window from its median.
// Depends on nothing.
module lsr_dev5 #(
  parameter int PIXEL_BITS = 16
) (
  input  logic signed [PIXEL_BITS-1:0] win [5],
  output logic        [PIXEL_BITS-1:0] dev
);

  logic signed [PIXEL_BITS-1:0] med;
  logic signed [PIXEL_BITS:0]   diff;
  logic signed [PIXEL_BITS:0]   neg;

  // The median is the element of rank two, ties broken by position.
  always_comb begin
    int rank;
    med = win[0];
    for (int i = 0; i < 5; i++) begin
      rank = 0;
      for (int j = 0; j < 5; j++) begin
        if (j != i && (win[j] < win[i] || (win[j] == win[i] && j < i))) begin
          rank = rank + 1;
        end
      end
      if (rank == 2) begin
        med = win[i];
      end
    end
  end

  assign diff = (PIXEL_BITS+1)'(win[2]) - (PIXEL_BITS+1)'(med);
  assign neg  = -diff;
  assign dev  = diff[PIXEL_BITS] ? neg[PIXEL_BITS-1:0] : diff[PIXEL_BITS-1:0];

endmodule

>>> design/lsr_div.sv
// Bit-serial restoring divider of a magnitude by a small count of 1 to 4.
// Depends on lsr_pkg for the status struct.
module lsr_div import lsr_pkg::*; #(
  parameter int MAG_BITS = 18
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [MAG_BITS-1:0] mag,
  input  logic [2:0]          divisor,
  output logic [MAG_BITS-1:0] quot,
  output div_status_t         status
);

  localparam int CW = $clog2(MAG_BITS + 1);

  logic [MAG_BITS-1:0] work;
  logic [2:0]          rem;
  logic [3:0]          trial;
  logic [CW-1:0]       cnt;

  assign trial = {rem, work[MAG_BITS-1]};
  assign quot  = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        status.busy <= 1'b1;
        work        <= mag;
        rem         <= '0;
        cnt         <= CW'(MAG_BITS);
      end else if (status.busy) begin
        // The quotient bits shift in where the dividend bits leave.
        if (trial >= {1'b0, divisor}) begin
          rem  <= 3'(trial - {1'b0, divisor});
          work <= {work[MAG_BITS-2:0], 1'b1};
        end else begin
          rem  <= trial[2:0];
          work <= {work[MAG_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

endmodule
